// ----- hw/rtl/sblv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblv_pkg
// Shared constants and functions of the spectrum band LED visualizer.
// ----------------------------------------------------------------------------
package sblv_pkg;

    localparam int NUM_BANDS_DEF  = 21;
    localparam int FFT_POINTS_DEF = 1024;
    localparam int EW             = 38;   // energy width
    localparam int HW             = 11;   // hue width
    localparam logic [15:0] DECAY_RST = 16'd36045;
    localparam logic [31:0] SEED_RST  = 32'd1;
    localparam logic [10:0] HUE_RANGE = 11'd1536;

    // configuration register indexes
    localparam logic [0:0] REG_DECAY = 1'b0;
    localparam logic [0:0] REG_SEED  = 1'b1;

    // first bin of band k; entry 21 is one past the top band
    function automatic logic [9:0] band_edge(input logic [4:0] k);
        logic [9:0] e;
        unique case (k)
            5'd0:  e = 10'd7;   5'd1:  e = 10'd9;   5'd2:  e = 10'd11;
            5'd3:  e = 10'd13;  5'd4:  e = 10'd17;  5'd5:  e = 10'd20;
            5'd6:  e = 10'd25;  5'd7:  e = 10'd30;  5'd8:  e = 10'd37;
            5'd9:  e = 10'd45;  5'd10: e = 10'd56;  5'd11: e = 10'd68;
            5'd12: e = 10'd83;  5'd13: e = 10'd101; 5'd14: e = 10'd124;
            5'd15: e = 10'd151; 5'd16: e = 10'd184; 5'd17: e = 10'd225;
            5'd18: e = 10'd275; 5'd19: e = 10'd335; 5'd20: e = 10'd409;
            default: e = 10'd500;
        endcase
        return e;
    endfunction

    // one xorshift32 step
    function automatic logic [31:0] xs_step(input logic [31:0] x0);
        logic [31:0] x;
        x = x0 ^ (x0 << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

// ----- hw/rtl/sblv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblv_div
// Restoring divider: floor(num / den) for a 46-bit numerator, one bit a cycle.
// ----------------------------------------------------------------------------
module sblv_div
    import sblv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [EW+7:0]     num,
    input  logic [EW-1:0]     den,
    output logic              done,
    output logic [EW+7:0]     quo
);
    localparam int NW = EW + 8;

    logic [NW-1:0] q_reg, q_next;
    logic [EW:0]   r_reg, r_next;
    logic [EW-1:0] d_reg, d_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [EW:0]   trial;

    // shift in one numerator bit, subtract when it fits
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[EW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = 6'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

// ----- hw/rtl/spectrum_band_led_visualizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_led_visualizer
// Sums FFT bin power into bands, tracks a decaying history per band and
// turns it into one RGB color per band at frame end when show_leds is set.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | content
// s_axis  | in  | tvalid/tready      | tdata: bin_real, bin_imag; tlast: frame_last;
//         |     |                    | tuser: show_leds
// m_axis  | out | tvalid/tready      | tdata: led_index, red, green, blue; tlast: run_end
// cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// For each bin the squares are registered, then the sum is accumulated and the
// band energy memory written; no new bin is taken before that. A frame-end item
// walks the bands: S_MUL and S_WR per band for the hue and history pass over the
// memories, then with LEDs shown per band load, 46-step bit-serial brightness
// divider, wait and output, with the divider skipped when all history is zero.
// Reset clears the small history and hue memories by a pass in S_CLR before input
// is taken. Output stalls hold the walk; no input is taken until the walk is done.
// ----------------------------------------------------------------------------
module spectrum_band_led_visualizer
    import sblv_pkg::*;
#(
    parameter int NUM_BANDS  = NUM_BANDS_DEF,
    parameter int FFT_POINTS = FFT_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] bin_real, [31:16] bin_imag
    input  logic        s_axis_tlast,   // frame_last
    input  logic        s_axis_tuser,   // show_leds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] led_index, [12:5] red,
                                        // [20:13] green, [28:21] blue, zero fill
    output logic        m_axis_tlast,   // run_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int BW = $clog2(NUM_BANDS + 1);
    localparam int CW = $clog2(FFT_POINTS);

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_ACC  = 10'b0000000100,
        S_RD   = 10'b0000001000,
        S_MUL  = 10'b0000010000,
        S_WR   = 10'b0000100000,
        S_LRD  = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_DIVW = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // memories: energy, history, hue
    logic [EW-1:0] energy_mem [NUM_BANDS];
    logic [EW-1:0] hist_mem   [NUM_BANDS];
    logic [HW-1:0] hue_mem    [NUM_BANDS];
    logic [EW-1:0] energy_rd, hist_rd;
    logic [HW-1:0] hue_rd;
    logic [BW-1:0] raddr, waddr;
    logic          e_we, h_we;
    logic [EW-1:0] e_wd, h_wd;
    logic [HW-1:0] u_wd;

    logic [15:0]   decay_reg;
    logic [31:0]   rnd_reg, rnd_next;
    logic [CW-1:0] bin_reg, bin_next;
    logic [EW-1:0] acc_reg, acc_next;
    logic [BW-1:0] band_reg, band_next;
    logic [BW-1:0] open_reg, open_next;      // band the accumulator belongs to
    logic [EW-1:0] max_reg, max_next;
    logic          last_reg, show_reg;
    logic [31:0]   sq_re_reg, sq_im_reg;
    logic [CW-1:0] idx_reg;
    logic [EW+15:0] prod_reg;
    logic [HW-1:0] hue_reg;
    logic [7:0]    v_reg;
    logic [31:0]   mtd_reg;
    logic          mlast_reg, mvalid_reg;

    logic          div_start, div_done;
    logic [EW+7:0] div_num, div_quo;

    sblv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (max_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign div_num = {8'd0, hist_rd} * (EW + 8)'(255);

    // memory ports, registered read
    always_ff @(posedge clk)
    begin
        if (e_we)
            energy_mem[waddr] <= e_wd;
        if (h_we)
        begin
            hist_mem[waddr] <= h_wd;
            hue_mem[waddr]  <= u_wd;
        end
        energy_rd <= energy_mem[raddr];
        hist_rd   <= hist_mem[raddr];
        hue_rd    <= hue_mem[raddr];
    end

    // band lookup for the registered bin
    logic          in_range, band_end;
    logic [CW:0]   idx_ext;
    logic [EW-1:0] acc_sum;
    always_comb
    begin
        idx_ext  = {1'b0, idx_reg};
        in_range = (idx_ext >= (CW+1)'(band_edge(5'd0)))
                && (idx_ext <  (CW+1)'(band_edge(5'(NUM_BANDS))));
        band_end = (idx_ext + 1'b1) == (CW+1)'(band_edge(5'(open_reg) + 5'd1));
        acc_sum  = acc_reg + EW'(sq_re_reg) + EW'(sq_im_reg);
    end

    // hue update and decayed history
    logic          trig;
    logic [EW+3:0] e10, h11;
    logic [EW-1:0] hdec, hnew;
    logic [31:0]   xs;
    logic [HW-1:0] hue_new;
    logic [42:0]   hue_prod;
    always_comb
    begin
        e10      = {1'b0, energy_rd, 3'b0} + {3'b0, energy_rd, 1'b0};
        h11      = {1'b0, hist_rd, 3'b0} + {3'b0, hist_rd, 1'b0} + {4'b0, hist_rd};
        trig     = e10 > h11;
        xs       = xs_step(rnd_reg);
        hue_prod = {11'd0, xs} * 43'(HUE_RANGE);
        hue_new  = trig ? hue_prod[42:32] : hue_rd;
        hdec     = prod_reg[EW+15:16];
        hnew     = (energy_rd > hdec) ? energy_rd : hdec;
    end

    // color wheel; divide by 255 as (x + x/256 + 1) / 256
    logic [2:0]  seg;
    logic [7:0]  pos, npos, rise, fall, r, g, b;
    logic [15:0] pr, pf, pr_q, pf_q;
    always_comb
    begin
        seg  = hue_reg[10:8];
        pos  = hue_reg[7:0];
        npos = 8'd255 - pos;
        pr   = 16'(v_reg) * 16'(pos);
        pf   = 16'(v_reg) * 16'(npos);
        pr_q = pr + 16'(pr[15:8]) + 16'd1;
        pf_q = pf + 16'(pf[15:8]) + 16'd1;
        rise = pr_q[15:8];
        fall = pf_q[15:8];
        unique case (seg)
            3'd0:    begin r = v_reg; g = rise;  b = 8'd0;  end
            3'd1:    begin r = fall;  g = v_reg; b = 8'd0;  end
            3'd2:    begin r = 8'd0;  g = v_reg; b = rise;  end
            3'd3:    begin r = 8'd0;  g = fall;  b = v_reg; end
            3'd4:    begin r = rise;  g = 8'd0;  b = v_reg; end
            default: begin r = v_reg; g = 8'd0;  b = fall;  end
        endcase
    end

    // control
    logic s_acc, m_free;
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign m_free = !mvalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !(cfg_valid);
    assign cfg_ready     = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        acc_next   = acc_reg;
        band_next  = band_reg;
        open_next  = open_reg;
        max_next   = max_reg;
        rnd_next   = rnd_reg;
        raddr      = band_reg;
        waddr      = band_reg;
        e_we       = 1'b0;
        h_we       = 1'b0;
        e_wd       = acc_sum;
        h_wd       = hnew;
        u_wd       = hue_new;
        div_start  = 1'b0;
        // seed write reloads the generator; zero would stick
        if (cfg_valid && cfg_ready && cfg_index == REG_SEED)
            rnd_next = (cfg_data == '0) ? 32'd1 : cfg_data;
        unique case (state_reg)
            S_CLR:
            begin
                h_we = 1'b1;
                h_wd = '0;
                u_wd = '0;
                band_next = band_reg + 1'b1;
                if (band_reg == BW'(NUM_BANDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_acc)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                waddr = open_reg;
                if (in_range)
                begin
                    acc_next = acc_sum;
                    if (band_end)
                    begin
                        e_we      = 1'b1;
                        acc_next  = '0;
                        open_next = open_reg + 1'b1;
                    end
                end
                // counter wrap starts the band walk over
                if (idx_reg == CW'(FFT_POINTS - 1))
                    open_next = '0;
                bin_next = (idx_reg == CW'(FFT_POINTS - 1)) ? '0 : idx_reg + 1'b1;
                state_next = S_IDLE;
                if (last_reg)
                begin
                    bin_next   = '0;
                    acc_next   = '0;
                    open_next  = '0;
                    band_next  = '0;
                    max_next   = '0;
                    raddr      = '0;
                    state_next = S_MUL;
                    // band 0 energy is read again in S_MUL, after any
                    // write made this cycle
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                h_we = 1'b1;
                if (trig)
                    rnd_next = xs;
                if (hnew > max_reg)
                    max_next = hnew;
                band_next = band_reg + 1'b1;
                raddr     = band_reg + 1'b1;
                if (band_reg == BW'(NUM_BANDS - 1))
                begin
                    band_next  = '0;
                    raddr      = '0;
                    state_next = show_reg ? S_LRD : S_IDLE;
                end
                else
                    state_next = S_MUL;
            end
            S_LRD:
            begin
                if (max_reg == '0)
                    state_next = S_DIVW;
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DIVW;
            end
            S_DIVW:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_free)
                begin
                    band_next = band_reg + 1'b1;
                    raddr     = band_reg + 1'b1;
                    state_next = (band_reg == BW'(NUM_BANDS - 1)) ? S_IDLE : S_LRD;
                end
                else
                    raddr = band_reg;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            decay_reg  <= DECAY_RST;
            rnd_reg    <= SEED_RST;
            bin_reg    <= '0;
            acc_reg    <= '0;
            band_reg   <= '0;
            open_reg   <= '0;
            max_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            acc_reg   <= acc_next;
            band_reg  <= band_next;
            open_reg  <= open_next;
            max_reg   <= max_next;
            rnd_reg   <= rnd_next;
            if (cfg_valid && cfg_ready && cfg_index == REG_DECAY)
                decay_reg <= cfg_data[15:0];
            if (state_reg == S_OUT && m_free)
                mvalid_reg <= 1'b1;
            else if (m_axis_tready)
                mvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    logic [EW+8:0] vq;
    assign vq = {1'b0, div_quo};
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            sq_re_reg <= 32'($signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[15:0]));
            sq_im_reg <= 32'($signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]));
            last_reg  <= s_axis_tlast;
            show_reg  <= s_axis_tuser;
            idx_reg   <= bin_reg;
        end
        prod_reg <= hist_rd * decay_reg;
        if (state_reg == S_LRD)
        begin
            hue_reg <= hue_rd;
            v_reg   <= '0;
        end
        else if (state_reg == S_DIV && div_done)
            v_reg <= (vq > (EW+9)'(255)) ? 8'd255 : div_quo[7:0];
        if (state_reg == S_OUT && m_free)
        begin
            mtd_reg   <= {3'b0, b, g, r, 5'(band_reg)};
            mlast_reg <= (band_reg == BW'(NUM_BANDS - 1));
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mtd_reg;
    assign m_axis_tlast  = mlast_reg;
endmodule

// ----- hw/rtl/sblv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblv_checker
// Port-level checks of the visualizer, bound to the top level.
// ----------------------------------------------------------------------------
module sblv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    // stalled output transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("output changed under stall");

    // led index in range
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= 5'd20)
        else $error("led index out of range");

    // run end only on the top band
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == 5'd20)
        else $error("run end on wrong band");

    // no input taken while configuration is written
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input and config in same cycle");
endmodule

bind spectrum_band_led_visualizer sblv_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
